@@ src/msv_pkg.sv @@
`default_nettype none
package msv_pkg;

	// Characters in one hash (a power of two), its log2, and the largest chunk count whose
	// hash region fits 64 bits
	localparam int unsigned HashChars  = 64;
	localparam int unsigned HashShift  = $clog2(HashChars);
	localparam logic [63:0] CountLimit = 64'hFFFF_FFFF_FFFF_FFFF / HashChars;

	localparam logic [31:0] VersionReset = 32'd1;

	// Record signature, first byte first
	localparam logic [7:0] MagicBytes [8] = '{
		8'h4E, 8'h45, 8'h58, 8'h55, 8'h53, 8'h46, 8'h53, 8'h4D
	};

	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;
	localparam logic [7:0] CharLowA  = 8'h61;
	localparam logic [7:0] CharLowF  = 8'h66;

	typedef enum logic [0:0] {
		ReqStart = 1'b0,
		ReqByte  = 1'b1
	} req_type_t;

	typedef enum logic [3:0] {
		SegMagic   = 4'd0,
		SegVersion = 4'd1,
		SegFsize   = 4'd2,
		SegCsize   = 4'd3,
		SegNlen    = 4'd4,
		SegName    = 4'd5,
		SegCount   = 4'd6,
		SegHash    = 4'd7,
		SegNone    = 4'd8
	} seg_t;

	typedef enum logic [3:0] {
		StBusy       = 4'd0,
		StOk         = 4'd1,
		StMagic      = 4'd2,
		StVersion    = 4'd3,
		StTrunc      = 4'd4,
		StShort      = 4'd5,
		StTrail      = 4'd6,
		StBadHash    = 4'd7,
		StOverflow   = 4'd8,
		StUnexpected = 4'd9
	} status_t;

	typedef struct packed {
		logic        req_type;
		logic [63:0] total_length;
		logic [7:0]  byte_value;
	} item_t;

	typedef struct packed {
		logic [3:0]  segment;
		logic [63:0] field_value;
		logic        value_valid;
		logic [3:0]  status;
		logic        record_done;
	} result_t;

endpackage
`default_nettype wire

@@ src/msv_if.sv @@
`default_nettype none
interface msv_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [63:0] total_length;
	logic [7:0]  byte_value;

	modport source (output valid, req_type, total_length, byte_value, input ready);
	modport sink   (input valid, req_type, total_length, byte_value, output ready);
endinterface

interface msv_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  segment;
	logic [63:0] field_value;
	logic        value_valid;
	logic [3:0]  status;
	logic        record_done;

	modport source (output valid, segment, field_value, value_valid, status, record_done,
		input ready);
	modport sink   (input valid, segment, field_value, value_valid, status, record_done,
		output ready);
endinterface

interface msv_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ src/msv_step.sv @@
`default_nettype none
module msv_step (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [31:0]     cfg_data,
	input  wire logic            advance,
	input  wire msv_pkg::item_t  item,
	output msv_pkg::result_t     result
);
	import msv_pkg::*;

	typedef enum logic [3:0] {
		PhIdle    = 4'd0,
		PhMagic   = 4'd1,
		PhVersion = 4'd2,
		PhFsize   = 4'd3,
		PhCsize   = 4'd4,
		PhNlen    = 4'd5,
		PhName    = 4'd6,
		PhCount   = 4'd7,
		PhHash    = 4'd8,
		PhDone    = 4'd9
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [6:0]  fbc_q, fbc_d;
	logic [63:0] acc_q, acc_d;
	logic [63:0] bytes_left_q, bytes_left_d;
	logic [63:0] name_left_q, name_left_d;
	logic [63:0] hashes_left_q, hashes_left_d;
	status_t     latched_q, latched_d;
	logic [31:0] version_q;

	seg_t        seg;
	logic [63:0] bl_dec;
	logic [63:0] acc_next;
	logic [63:0] need;
	logic [63:0] name_dec;
	logic [63:0] hash_dec;
	logic [6:0]  fbc_inc;
	logic [6:0]  width;
	logic        is_hex;
	logic        fixed_phase;

	always_comb begin
		unique case (phase_q)
			PhMagic:   seg = SegMagic;
			PhVersion: seg = SegVersion;
			PhFsize:   seg = SegFsize;
			PhCsize:   seg = SegCsize;
			PhNlen:    seg = SegNlen;
			PhName:    seg = SegName;
			PhCount:   seg = SegCount;
			PhHash:    seg = SegHash;
			default:   seg = SegNone;
		endcase
	end

	assign bl_dec   = bytes_left_q - 64'd1;
	assign acc_next = {acc_q[55:0], item.byte_value};
	// wrapped bits only matter past CountLimit, which is caught first
	assign need     = acc_next << HashShift;
	assign name_dec = (name_left_q != 64'd0) ? name_left_q - 64'd1 : 64'd0;
	assign hash_dec = (hashes_left_q != 64'd0) ? hashes_left_q - 64'd1 : 64'd0;
	assign fbc_inc  = fbc_q + 7'd1;
	assign width    = (phase_q == PhVersion) ? 7'd4 : 7'd8;
	assign is_hex   = (item.byte_value >= CharZero && item.byte_value <= CharNine) ||
		(item.byte_value >= CharLowA && item.byte_value <= CharLowF);

	always_comb begin
		phase_d       = phase_q;
		fbc_d         = fbc_q;
		acc_d         = acc_q;
		bytes_left_d  = bytes_left_q;
		name_left_d   = name_left_q;
		hashes_left_d = hashes_left_q;
		latched_d     = latched_q;
		result        = '{segment: SegNone, field_value: 64'd0, value_valid: 1'b0,
			status: StBusy, record_done: 1'b0};
		fixed_phase   = 1'b0;

		if (item.req_type == ReqStart) begin
			phase_d       = PhMagic;
			fbc_d         = 7'd0;
			acc_d         = 64'd0;
			bytes_left_d  = item.total_length;
			name_left_d   = 64'd0;
			hashes_left_d = 64'd0;
			latched_d     = StBusy;
			if (item.total_length == 64'd0) begin
				phase_d            = PhDone;
				latched_d          = StTrunc;
				result.status      = StTrunc;
				result.record_done = 1'b1;
			end
		end else if (phase_q == PhIdle) begin
			result.status = StUnexpected;
		end else if (phase_q == PhDone) begin
			result.status      = latched_q;
			result.record_done = 1'b1;
		end else if (bytes_left_q == 64'd0) begin
			phase_d            = PhDone;
			latched_d          = StTrunc;
			result.segment     = seg;
			result.status      = StTrunc;
			result.record_done = 1'b1;
		end else begin
			bytes_left_d   = bl_dec;
			result.segment = seg;
			if (phase_q == PhName) begin
				result.field_value = {56'd0, item.byte_value};
				result.value_valid = 1'b1;
				name_left_d        = name_dec;
				if (name_dec == 64'd0)
					phase_d = PhCount;
			end else if (phase_q == PhHash) begin
				if (!is_hex) begin
					phase_d   = PhDone;
					latched_d = StBadHash;
				end else if (fbc_inc >= 7'(HashChars)) begin
					fbc_d         = 7'd0;
					hashes_left_d = hash_dec;
					if (hash_dec == 64'd0) begin
						phase_d   = PhDone;
						latched_d = StOk;
					end
				end else begin
					fbc_d = fbc_inc;
				end
			end else if (phase_q == PhMagic && item.byte_value != MagicBytes[fbc_q[2:0]]) begin
				phase_d   = PhDone;
				latched_d = StMagic;
			end else if (fbc_inc >= width) begin
				fbc_d              = 7'd0;
				acc_d              = 64'd0;
				result.field_value = acc_next;
				result.value_valid = 1'b1;
				unique case (phase_q)
					PhVersion: begin
						if (acc_next[31:0] != version_q) begin
							phase_d   = PhDone;
							latched_d = StVersion;
						end else begin
							phase_d = PhFsize;
						end
					end
					PhNlen: begin
						name_left_d = acc_next;
						if (acc_next > bl_dec) begin
							phase_d   = PhDone;
							latched_d = StTrunc;
						end else begin
							phase_d = (acc_next == 64'd0) ? PhCount : PhName;
						end
					end
					PhCount: begin
						// hash region must exactly fill what is left
						if (acc_next > CountLimit) begin
							phase_d   = PhDone;
							latched_d = StOverflow;
						end else if (bl_dec < need) begin
							phase_d   = PhDone;
							latched_d = StShort;
						end else if (bl_dec > need) begin
							phase_d   = PhDone;
							latched_d = StTrail;
						end else if (need == 64'd0) begin
							phase_d   = PhDone;
							latched_d = StOk;
						end else begin
							hashes_left_d = acc_next;
							phase_d       = PhHash;
						end
					end
					PhMagic:   phase_d = PhVersion;
					PhFsize:   phase_d = PhCsize;
					PhCsize:   phase_d = PhNlen;
					default:   phase_d = phase_q;
				endcase
			end else begin
				acc_d = acc_next;
				fbc_d = fbc_inc;
			end

			fixed_phase = phase_d == PhMagic || phase_d == PhVersion || phase_d == PhFsize ||
				phase_d == PhCsize || phase_d == PhNlen || phase_d == PhCount;
			if (fixed_phase && bl_dec == 64'd0) begin
				phase_d   = PhDone;
				latched_d = StTrunc;
			end

			if (phase_d == PhDone) begin
				if (latched_d != StOk) begin
					result.field_value = 64'd0;
					result.value_valid = 1'b0;
				end
				result.status      = latched_d;
				result.record_done = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PhIdle;
			fbc_q         <= 7'd0;
			acc_q         <= 64'd0;
			bytes_left_q  <= 64'd0;
			name_left_q   <= 64'd0;
			hashes_left_q <= 64'd0;
			latched_q     <= StBusy;
			version_q     <= VersionReset;
		end else begin
			if (cfg_we)
				version_q <= cfg_data;
			if (advance) begin
				phase_q       <= phase_d;
				fbc_q         <= fbc_d;
				acc_q         <= acc_d;
				bytes_left_q  <= bytes_left_d;
				name_left_q   <= name_left_d;
				hashes_left_q <= hashes_left_d;
				latched_q     <= latched_d;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/manifest_stream_validator_unit.sv @@
`default_nettype none
// Channel  Modport  Moves
// req      sink     one start request (total_length) or one record byte
// rsp      source   segment, field_value, value_valid, status, record_done
// cfg      sink     expected_version write data
//
// One request a cycle sustained while rsp is ready; each passes the input and output registers.
// Requests are registered, parsed combinationally against the record state, and the
// result lands in an output register; the state advances only as that register loads.
// A stalled rsp holds its result while one more request waits in the input stage.
// Reset clears the record state and sets expected_version to 1.
module manifest_stream_validator_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	msv_req_if.sink    req,
	msv_rsp_if.source  rsp,
	msv_cfg_if.sink    cfg
);
	import msv_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    rsp_valid_q;
	result_t rsp_q;
	result_t step_result;
	logic    advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	msv_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.advance  (advance),
		.item     (item_s1),
		.result   (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (advance)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			item_s1 <= '{req_type: req.req_type, total_length: req.total_length,
				byte_value: req.byte_value};
		if (advance)
			rsp_q <= step_result;
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.segment     = rsp_q.segment;
	assign rsp.field_value = rsp_q.field_value;
	assign rsp.value_valid = rsp_q.value_valid;
	assign rsp.status      = rsp_q.status;
	assign rsp.record_done = rsp_q.record_done;

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import msv_pkg::*;

	localparam int unsigned RequestTarget = 950;
	localparam int unsigned CycleLimit    = 100000;
	localparam int unsigned DrainCycles   = 6;
	localparam int unsigned ReportLimit   = 10;
	localparam int unsigned SteadyFrom    = 420;
	localparam int unsigned SteadyTo      = 620;
	localparam int unsigned HeadBytes     = 44;

	typedef enum logic [3:0] {
		PhIdle, PhMagic, PhVersion, PhFsize, PhCsize, PhNlen, PhName, PhCount, PhHash, PhDone
	} parse_phase_t;

	typedef enum int {
		RkGood, RkBadMagic, RkBadVersion, RkCut, RkTrailing, RkHashShort, RkBadHash,
		RkOverflow, RkNameTooLong, RkAbandon, RkNoise
	} record_kind_t;

	logic clk;
	logic arst_n;

	msv_req_if req ();
	msv_rsp_if rsp ();
	msv_cfg_if cfg ();

	manifest_stream_validator_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// Parser state as the block should hold it
	parse_phase_t rec_phase   = PhIdle;
	logic [6:0]   digit_count = '0;
	logic [63:0]  field_acc   = '0;
	logic [63:0]  record_left = '0;
	logic [63:0]  name_left   = '0;
	logic [63:0]  hash_left   = '0;
	status_t      record_status = StBusy;
	logic [31:0]  version_reg = VersionReset;

	result_t     pending_results [$];
	logic [7:0]  record_bytes [$];
	int unsigned requests_sent   = 0;
	int unsigned parsed_requests = 0;
	int unsigned starts_seen     = 0;
	int unsigned results_checked = 0;
	int unsigned version_writes  = 0;
	int unsigned mismatches      = 0;
	int unsigned cycle_count     = 0;
	int unsigned close_tally [16];
	logic        steady;

	assign steady = (requests_sent >= SteadyFrom) && (requests_sent < SteadyTo);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void close_record(input status_t st);
		rec_phase = PhDone;
		record_status = st;
		close_tally[st]++;
	endfunction

	function automatic result_t parse_request(input item_t it);
		result_t      res;
		seg_t         seg;
		parse_phase_t cur;
		logic [63:0]  val;
		logic [63:0]  need;
		logic         valid;
		logic [7:0]   b;
		int unsigned  width;
		res = '0;
		val = '0;
		valid = 1'b0;
		b = it.byte_value;
		if (it.req_type == ReqStart) begin
			starts_seen++;
			parsed_requests++;
			rec_phase = PhMagic;
			digit_count = '0;
			field_acc = '0;
			record_left = it.total_length;
			name_left = '0;
			hash_left = '0;
			record_status = StBusy;
			if (record_left == '0)
				close_record(StTrunc);
			res.segment = SegNone;
			res.status = record_status;
			res.record_done = (rec_phase == PhDone);
			return res;
		end
		if (rec_phase == PhIdle) begin
			res.segment = SegNone;
			res.status = StUnexpected;
			return res;
		end
		if (rec_phase == PhDone) begin
			res.segment = SegNone;
			res.status = record_status;
			res.record_done = 1'b1;
			return res;
		end
		parsed_requests++;
		seg = seg_t'(rec_phase - PhMagic);
		if (record_left == '0) begin
			close_record(StTrunc);
			res.segment = seg;
			res.status = StTrunc;
			res.record_done = 1'b1;
			return res;
		end
		record_left--;

		if (rec_phase == PhName) begin
			val = 64'(b);
			valid = 1'b1;
			if (name_left != '0)
				name_left--;
			if (name_left == '0)
				rec_phase = PhCount;
		end else if (rec_phase == PhHash) begin
			if (!(b inside {[CharZero:CharNine], [CharLowA:CharLowF]})) begin
				close_record(StBadHash);
			end else begin
				digit_count++;
				if (digit_count >= HashChars) begin
					digit_count = '0;
					if (hash_left != '0)
						hash_left--;
					if (hash_left == '0)
						close_record(StOk);
				end
			end
		end else begin
			width = (rec_phase == PhVersion) ? 4 : 8;
			if (rec_phase == PhMagic && b != MagicBytes[digit_count[2:0]]) begin
				close_record(StMagic);
			end else begin
				field_acc = {field_acc[55:0], b};
				digit_count++;
				if (digit_count >= width) begin
					cur = rec_phase;
					val = field_acc;
					valid = 1'b1;
					digit_count = '0;
					field_acc = '0;
					case (cur)
					PhVersion: begin
						if (val[31:0] != version_reg)
							close_record(StVersion);
						else
							rec_phase = PhFsize;
					end
					PhNlen: begin
						name_left = val;
						if (val > record_left)
							close_record(StTrunc);
						else
							rec_phase = (val == '0) ? PhCount : PhName;
					end
					PhCount: begin
						// the hash region must fill what is left exactly
						need = val * HashChars;
						if (val > CountLimit)
							close_record(StOverflow);
						else if (record_left < need)
							close_record(StShort);
						else if (record_left > need)
							close_record(StTrail);
						else if (need == '0)
							close_record(StOk);
						else begin
							hash_left = val;
							digit_count = '0;
							rec_phase = PhHash;
						end
					end
					default: rec_phase = cur.next();
					endcase
				end
			end
		end

		if (rec_phase inside {PhMagic, PhVersion, PhFsize, PhCsize, PhNlen, PhCount} &&
				record_left == '0)
			close_record(StTrunc);

		res.segment = seg;
		if (rec_phase == PhDone) begin
			res.value_valid = (record_status == StOk) ? valid : 1'b0;
			res.status = record_status;
			res.record_done = 1'b1;
		end else begin
			res.value_valid = valid;
			res.status = StBusy;
		end
		res.field_value = res.value_valid ? val : '0;
		return res;
	endfunction

	task automatic send_request(input req_type_t kind, input logic [63:0] len,
			input logic [7:0] value);
		item_t it;
		logic  taken;
		while (!steady && $urandom_range(0, 99) < 20) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		it.req_type = kind;
		it.total_length = len;
		it.byte_value = value;
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.total_length <= len;
		req.byte_value <= value;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = req.ready;
			@(posedge clk);
		end
		pending_results.insert(pending_results.size(), parse_request(it));
		requests_sent++;
	endtask

	task automatic send_start(input logic [63:0] len);
		send_request(ReqStart, len, 8'($urandom));
	endtask

	task automatic send_byte(input logic [7:0] value);
		send_request(ReqByte, {$urandom, $urandom}, value);
	endtask

	// Hold requests back until every result has come, then let the pipe settle
	task automatic drain_results;
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_version(input logic [31:0] setting);
		logic taken;
		cfg.valid <= 1'b1;
		cfg.data <= setting;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg.ready;
			@(posedge clk);
		end
		cfg.valid <= 1'b0;
		version_reg = setting;
		version_writes++;
	endtask

	function automatic void push_be(input logic [63:0] v, input int nbytes);
		for (int i = nbytes - 1; i >= 0; i--)
			record_bytes.insert(record_bytes.size(), v[8 * i +: 8]);
	endfunction

	function automatic void build_record(input logic [31:0] ver, input logic [63:0] nlen_field,
			input int unsigned name_bytes, input logic [63:0] count_field,
			input int unsigned hashes);
		int unsigned k;
		record_bytes.delete();
		for (int i = 0; i < 8; i++)
			record_bytes.insert(record_bytes.size(), MagicBytes[i]);
		push_be(64'(ver), 4);
		push_be({$urandom, $urandom}, 8);
		push_be({$urandom, $urandom}, 8);
		push_be(nlen_field, 8);
		repeat (name_bytes) record_bytes.insert(record_bytes.size(), 8'($urandom));
		push_be(count_field, 8);
		repeat (hashes * HashChars) begin
			k = $urandom_range(0, 15);
			record_bytes.insert(record_bytes.size(),
				k < 10 ? CharZero + 8'(k) : CharLowA + 8'(k - 10));
		end
	endfunction

	task automatic run_record(input record_kind_t kind);
		int unsigned nlen;
		int unsigned hashes;
		int unsigned head;
		int unsigned pos;
		int unsigned upto;
		int unsigned hold_at;
		int unsigned extra;
		int unsigned i;
		logic [63:0] total;
		logic [63:0] count_field;
		logic [63:0] nlen_field;
		logic [31:0] ver;
		logic [7:0]  flip;

		if (kind == RkNoise) begin
			repeat ($urandom_range(4, 12)) begin
				if ($urandom_range(0, 3) == 0)
					send_start({$urandom, $urandom} >> $urandom_range(0, 63));
				else
					send_byte(8'($urandom));
			end
			return;
		end

		nlen = $urandom_range(0, 5);
		pos = $urandom_range(0, 99);
		hashes = (pos < 45) ? 0 : (pos < 90) ? 1 : 2;
		if (kind inside {RkHashShort, RkBadHash} && hashes == 0)
			hashes = 1;
		if (kind inside {RkOverflow, RkNameTooLong})
			hashes = 0;
		ver = version_reg;
		if (kind == RkBadVersion)
			ver ^= ($urandom_range(0, 1) != 0) ? 32'd1 << $urandom_range(0, 31) : $urandom | 32'd1;
		count_field = 64'(hashes);
		extra = $urandom_range(0, 20);
		case (kind)
		RkOverflow: begin
			case ($urandom_range(0, 2))
			0: count_field = '1;
			1: count_field = CountLimit + 64'd1;
			default: count_field = CountLimit + 64'($urandom) + 64'd1;
			endcase
		end
		RkHashShort: begin
			if ($urandom_range(0, 3) == 0)
				count_field = CountLimit;
		end
		RkNameTooLong: begin
			nlen = 0;
		end
		default: ;
		endcase
		if (kind == RkNameTooLong)
			nlen_field = ($urandom_range(0, 1) != 0) ? 64'(extra + 1 + $urandom_range(0, 3)) :
				{1'b1, 31'($urandom), $urandom};
		else
			nlen_field = 64'(nlen);

		build_record(ver, nlen_field, nlen, count_field, hashes);
		head = HeadBytes + nlen;
		total = record_bytes.size();
		upto = record_bytes.size() + $urandom_range(0, 2);
		case (kind)
		RkBadMagic: begin
			pos = $urandom_range(0, 7);
			record_bytes[pos] ^= 8'($urandom_range(1, 255));
			upto = pos + 1 + $urandom_range(0, 2);
		end
		RkBadVersion: upto = 12 + $urandom_range(0, 2);
		RkCut: begin
			total = $urandom_range(1, record_bytes.size() - 1);
			upto = total + $urandom_range(0, 2);
		end
		RkTrailing: begin
			total = record_bytes.size() + $urandom_range(1, 80);
			upto = head + $urandom_range(0, 2);
		end
		RkHashShort: begin
			if (count_field != CountLimit)
				total = record_bytes.size() - $urandom_range(1, hashes * HashChars);
			upto = head + $urandom_range(0, 2);
		end
		RkBadHash: begin
			pos = $urandom_range(head, record_bytes.size() - 1);
			do
				flip = 8'($urandom);
			while (flip inside {[CharZero:CharNine], [CharLowA:CharLowF]});
			record_bytes[pos] = flip;
			upto = pos + 1 + $urandom_range(0, 2);
		end
		RkNameTooLong: begin
			total = 36 + extra;
			upto = 36 + $urandom_range(0, 2);
		end
		RkAbandon: upto = $urandom_range(1, record_bytes.size() - 1);
		default: ;
		endcase

		hold_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, upto) : upto + 1;
		send_start(total);
		for (i = 0; i < upto; i++) begin
			if (i == hold_at)
				drain_results();
			send_byte(i < record_bytes.size() ? record_bytes[i] : 8'($urandom));
		end
	endtask

	task automatic test_lone_requests;
		// no record open yet
		send_byte(8'h00);
		send_byte(8'hFF);
		// empty record truncates at once; a byte after repeats the verdict
		send_start('0);
		send_byte(MagicBytes[0]);
		// longest record, abandoned by the next start
		send_start('1);
		send_byte(MagicBytes[0]);
		send_byte(MagicBytes[1]);
		// run out of bytes inside the signature
		send_start(64'd3);
		send_byte(MagicBytes[0]);
		send_byte(MagicBytes[1]);
		send_byte(MagicBytes[2]);
		send_byte(8'hA5);
		send_start(64'd1);
		send_byte(MagicBytes[0]);
		// wrong first signature byte
		send_start(64'd20);
		send_byte(8'h4F);
		send_byte(8'h00);
	endtask

	task automatic test_version_register;
		logic [31:0] settings [3];
		settings = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom};
		run_record(RkGood);
		run_record(RkBadVersion);
		foreach (settings[i]) begin
			drain_results();
			write_version(settings[i]);
			run_record(RkGood);
			run_record(RkBadVersion);
		end
	endtask

	task automatic test_random_records;
		int unsigned rec_no;
		rec_no = 0;
		while (parsed_requests < RequestTarget) begin
			if (rec_no != 0 && rec_no % 6 == 0) begin
				drain_results();
				case ($urandom_range(0, 3))
				0: write_version(32'h0000_0000);
				1: write_version(32'hFFFF_FFFF);
				default: write_version($urandom);
				endcase
			end
			// every kind once, then a random mix in which well-formed records make up 40 percent
			if (rec_no <= RkNoise)
				run_record(record_kind_t'(rec_no));
			else if ($urandom_range(0, 99) < 40)
				run_record(RkGood);
			else
				run_record(record_kind_t'($urandom_range(RkBadMagic, RkNoise)));
			rec_no++;
		end
	endtask

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= steady || ($urandom_range(0, 99) >= 20);
		end
	end

	initial begin : result_checker
		result_t got;
		result_t want;
		forever begin
			@(negedge clk);
			if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				got.segment = rsp.segment;
				got.field_value = rsp.field_value;
				got.value_valid = rsp.value_valid;
				got.status = rsp.status;
				got.record_done = rsp.record_done;
				results_checked++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= ReportLimit)
						$display("unexpected result: segment %0d status %0d done %b",
							got.segment, got.status, got.record_done);
				end else begin
					want = pending_results.pop_front();
					if (got.segment !== want.segment || got.field_value !== want.field_value ||
							got.value_valid !== want.value_valid ||
							got.status !== want.status || got.record_done !== want.record_done) begin
						mismatches++;
						if (mismatches <= ReportLimit)
							$display({"mismatch on result %0d: segment %0d/%0d value %h/%h ",
								"vld %b/%b status %0d/%0d done %b/%b (exp/got)"},
								results_checked, want.segment, got.segment,
								want.field_value, got.field_value, want.value_valid,
								got.value_valid, want.status, got.status,
								want.record_done, got.record_done);
					end
				end
			end
		end
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.req_type <= ReqStart;
		req.total_length <= '0;
		req.byte_value <= '0;
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lone_requests();
		test_version_register();
		test_random_records();
		drain_results();

		$display("summary: %0d requests (%0d parsed), %0d records opened, %0d version writes",
			requests_sent, parsed_requests, starts_seen, version_writes);
		$display({"summary: closed accepted %0d, magic %0d, version %0d, truncated %0d, ",
			"short %0d, trailing %0d, bad hash %0d, overflow %0d"},
			close_tally[StOk], close_tally[StMagic], close_tally[StVersion],
			close_tally[StTrunc], close_tally[StShort], close_tally[StTrail],
			close_tally[StBadHash], close_tally[StOverflow]);
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
src/msv_pkg.sv
src/msv_if.sv
src/msv_step.sv
src/manifest_stream_validator_unit.sv
sim/testbench.sv
